// File: hw/rtl/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg
// shared types and constants for the manchester frame receiver
// ----------------------------------------------------------------------------
package mfr_pkg;

    localparam int LINE_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 11;
    localparam int KIND_W     = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [LINE_W-1:0] PREAMBLE_WORD = 16'h6666;
    localparam logic [LINE_W-1:0] SFD_WORD      = 16'ha666;
    localparam logic [LINE_W-1:0] ODD_MASK      = 16'haaaa;
    localparam logic [LINE_W-1:0] EVEN_MASK     = 16'h5555;

    localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 11'd1522;

    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP = 2'd2;

    // classified line word
    typedef struct packed {
        logic              low_zero;
        logic              high_zero;
        logic              valid;
        logic              is_pre;
        logic              is_sfd;
        logic [BYTE_W-1:0] data;
    } mfr_item_t;

endpackage

// File: hw/rtl/mfr_front.sv
// ----------------------------------------------------------------------------
// mfr_front
// accepts line words and classifies them for the frame state machine
// ----------------------------------------------------------------------------
module mfr_front
    import mfr_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [LINE_W-1:0] line_word,
    input  logic              q_full,
    output logic              q_push,
    output mfr_item_t         q_item
);

    logic [BYTE_W-1:0] decoded;

    always_comb begin
        for (int i = 0; i < BYTE_W; i++) begin
            decoded[i] = line_word[2*i+1];
        end
    end

    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & ~q_full;

    assign q_item.low_zero  = (line_word[7:0] == 8'h00);
    assign q_item.high_zero = (line_word[15:8] == 8'h00);
    assign q_item.valid     = (((line_word & ODD_MASK) >> 1) == (~line_word & EVEN_MASK));
    assign q_item.is_pre    = (line_word == PREAMBLE_WORD);
    assign q_item.is_sfd    = (line_word == SFD_WORD);
    assign q_item.data      = decoded;

endmodule

// File: hw/rtl/mfr_queue.sv
// ----------------------------------------------------------------------------
// mfr_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module mfr_queue
    import mfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  mfr_item_t push_item,
    output logic      full,
    input  logic      pop,
    output mfr_item_t pop_item,
    output logic      not_empty
);

    mfr_item_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count over depth");

    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers apart while empty");

endmodule

// File: hw/rtl/mfr_back.sv
// ----------------------------------------------------------------------------
// mfr_back
// frame state machine and registered result stage
// ----------------------------------------------------------------------------
module mfr_back
    import mfr_pkg::*;
#(
    parameter int PREAMBLE_WORDS = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [LEN_W-1:0]  cfg_wdata,
    input  logic              q_valid,
    input  mfr_item_t         q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIND_W-1:0] m_kind,
    output logic [BYTE_W-1:0] m_data,
    output logic [LEN_W-1:0]  m_count
);

    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_SKIP = 2'd2;
    localparam logic [2:0] PRE_TARGET = 3'(PREAMBLE_WORDS);

    logic [1:0]        mode_reg, mode_next;
    logic [2:0]        pre_reg, pre_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  max_reg;
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              emit;

    assign q_pop = q_valid & (~out_valid_reg | m_ready);

    always_comb begin
        mode_next  = mode_reg;
        pre_next   = pre_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        kind_next  = kind_reg;
        data_next  = data_reg;
        count_next = count_reg;
        if (q_pop) begin
            unique case (mode_reg)
                MODE_READ: begin
                    emit       = 1'b1;
                    data_next  = '0;
                    count_next = len_reg;
                    if (q_item.low_zero) begin
                        kind_next = KIND_END;
                        mode_next = MODE_HUNT;
                        pre_next  = '0;
                    end else if (len_reg >= max_reg || !q_item.valid) begin
                        kind_next = KIND_DROP;
                        mode_next = q_item.high_zero ? MODE_HUNT : MODE_SKIP;
                        pre_next  = '0;
                    end else begin
                        kind_next = KIND_DATA;
                        data_next = q_item.data;
                        len_next  = len_reg + 1'b1;
                    end
                end
                MODE_SKIP: begin
                    if (q_item.high_zero) begin
                        mode_next = MODE_HUNT;
                        pre_next  = '0;
                    end
                end
                default: begin
                    mode_next = MODE_HUNT;
                    if (q_item.is_pre) begin
                        pre_next = (pre_reg < PRE_TARGET) ? pre_reg + 1'b1 : 3'd1;
                    end else if (q_item.is_sfd && pre_reg == PRE_TARGET) begin
                        mode_next = MODE_READ;
                        len_next  = '0;
                        pre_next  = '0;
                    end else begin
                        pre_next = '0;
                    end
                end
            endcase
        end
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_HUNT;
            pre_reg       <= '0;
            len_reg       <= '0;
            max_reg       <= MAX_FRAME_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            pre_reg       <= pre_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                max_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            count_reg <= count_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = kind_reg;
    assign m_data  = data_reg;
    assign m_count = count_reg;

    a_mode_code: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != 2'd3)
        else $error("unused mode code reached");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (kind_reg == KIND_DATA || kind_reg == KIND_END
                           || kind_reg == KIND_DROP))
        else $error("bad result kind");

    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_reg != KIND_DATA) |-> (data_reg == '0))
        else $error("data byte set on end or drop");

    a_pre_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pre_reg <= PRE_TARGET)
        else $error("preamble count over target");

endmodule

// File: hw/rtl/manchester_frame_receiver.sv
// ----------------------------------------------------------------------------
// manchester_frame_receiver
// hunts for preamble and sfd, decodes manchester words into frame bytes
//
// channel   dir  tdata                                 tuser
// s_axis    in   [15:0] line_word                      -
// m_axis    out  [7:0] data_byte, [18:8] byte_count     [1:0] result_kind
// cfg       in   cfg_wdata [10:0] max_frame_bytes      -
//
// one beat per cycle sustained on both sides while m_tready stays high; a beat
// with a result shows on m_ once its word is written into the queue on the
// accepting edge and then popped into the result register
// a four-entry queue decouples word classification from the frame state
// machine, so s_tready drops only when the queue is full
// aresetn is synchronous; it clears the queue and frame state and restores the 1522 byte default limit
// ----------------------------------------------------------------------------
module manchester_frame_receiver
    import mfr_pkg::*;
#(
    parameter int PREAMBLE_WORDS = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] line_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [18:8] byte_count, rest zero
    output logic [1:0]  m_tuser    // [1:0] result_kind
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    mfr_item_t         push_item;
    mfr_item_t         pop_item;
    logic [BYTE_W-1:0] out_data;
    logic [LEN_W-1:0]  out_count;

    mfr_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .line_word (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    mfr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .not_empty (q_valid)
    );

    mfr_back #(
        .PREAMBLE_WORDS (PREAMBLE_WORDS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_kind    (m_tuser),
        .m_data    (out_data),
        .m_count   (out_count)
    );

    assign m_tdata = {5'd0, out_count, out_data};

endmodule
